// ===== design/dpf_pkg.sv =====
// Package with shared types and constants for the distinct prime filter.
package dpf_pkg;

  localparam int SeenDepthDefault = 64;
  localparam int ValueBits        = 32;
  localparam int PrimeBits        = 31;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 last_item;
  } in_word_t;

  typedef struct packed {
    logic [30:0] prime_value;
    logic        none_found;
    logic        store_full;
  } out_word_t;

endpackage

// ===== design/dpf_front.sv =====
// Front part: accepts words, marks trivial non-primes and queues every word.
module dpf_front import dpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  in_word_t             in_word,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic [ValueBits-1:0] q_value,
  output logic                 q_cand,
  output logic                 q_last,
  output logic                 q_valid,
  input  logic                 q_pop
);

  localparam int QDepth = 2;

  logic [ValueBits-1:0] qv [QDepth];
  logic                 qc [QDepth];
  logic                 ql [QDepth];
  logic                 wptr;
  logic                 rptr;
  logic [1:0]           cnt;
  logic                 push;
  logic [ValueBits-1:0] v;
  logic                 cand;

  assign v        = in_word.value;
  assign cand     = !v[ValueBits-1] && (v > ValueBits'(1));
  assign in_stall = (cnt == 2'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_value  = qv[rptr];
  assign q_cand   = qc[rptr];
  assign q_last   = ql[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qv[wptr] <= v;
      qc[wptr] <= cand;
      ql[wptr] <= in_word.last_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== design/dpf_back.sv =====
// Back part: trial division, seen-store search and result register.
module dpf_back import dpf_pkg::*; #(
  parameter int SEEN_DEPTH = SeenDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ValueBits-1:0] q_value,
  input  logic                 q_cand,
  input  logic                 q_last,
  input  logic                 q_valid,
  output logic                 q_pop,
  output out_word_t            out_word,
  output logic                 out_valid,
  input  logic                 out_stall
);

  localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CW = $clog2(SEEN_DEPTH + 1);
  localparam int VW = ValueBits;
  localparam int RW = VW + 1;
  localparam int BW = $clog2(VW + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_NEXT  = 7'b0001000,
    S_SRCH  = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t         state;
  logic [VW-1:0]  x;
  logic [VW-1:0]  xs;
  logic           last;
  logic           prime;
  logic           found;
  logic [VW-1:0]  k;
  logic [VW-1:0]  divisor;
  logic           second;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  quo;
  logic [BW-1:0]  bitn;
  logic [CW-1:0]  seen_count;
  logic [CW-1:0]  idx;
  logic [VW-1:0]  seen_primes [SEEN_DEPTH];
  logic [VW-1:0]  rd;
  logic [RW-1:0]  rem_sh;
  logic           sub_ok;
  logic           new_prime;
  logic           full;
  logic           out_free;

  assign rem_sh    = {rem, xs[VW-1]};
  assign sub_ok    = rem_sh >= {1'b0, divisor};
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign new_prime = prime && found;
  assign full      = seen_count >= CW'(SEEN_DEPTH);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free && new_prime && !full)
      seen_primes[seen_count[AW-1:0]] <= x;
    rd <= seen_primes[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      seen_count <= '0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= new_prime || (last && seen_count == '0);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            x     <= q_value;
            last  <= q_last;
            found <= 1'b1;
            prime <= q_cand;
            if (q_cand) state <= S_SETUP;
            else state <= S_OUT;
          end
        end
        S_SETUP: begin
          if (x == VW'(2) || x == VW'(3)) begin
            idx   <= '0;
            state <= S_SRCH;
          end else if (!x[0]) begin
            prime <= 1'b0;
            state <= S_OUT;
          end else begin
            divisor <= VW'(3);
            second  <= 1'b0;
            rem     <= '0;
            quo     <= '0;
            xs      <= x;
            bitn    <= BW'(VW);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= sub_ok ? VW'(rem_sh - {1'b0, divisor}) : rem_sh[VW-1:0];
          quo  <= {quo[VW-2:0], sub_ok};
          xs   <= {xs[VW-2:0], 1'b0};
          bitn <= bitn - BW'(1);
          if (bitn == BW'(1)) state <= S_NEXT;
        end
        S_NEXT: begin
          rem  <= '0;
          quo  <= '0;
          xs   <= x;
          bitn <= BW'(VW);
          if (divisor == VW'(3)) begin
            if (rem == '0) begin
              prime <= 1'b0;
              state <= S_OUT;
            end else begin
              divisor <= VW'(5);
              k       <= VW'(5);
              second  <= 1'b0;
              state   <= S_DIV;
            end
          end else if (!second) begin
            if (k > quo) begin
              idx   <= '0;
              state <= S_SRCH;
            end else if (rem == '0) begin
              prime <= 1'b0;
              state <= S_OUT;
            end else begin
              divisor <= k + VW'(2);
              second  <= 1'b1;
              state   <= S_DIV;
            end
          end else if (rem == '0) begin
            prime <= 1'b0;
            state <= S_OUT;
          end else begin
            k       <= k + VW'(6);
            divisor <= k + VW'(6);
            second  <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_SRCH: begin
          if (idx >= seen_count) state <= S_OUT;
          else state <= S_CMP;
        end
        S_CMP: begin
          if (rd == x) begin
            found <= 1'b0;
            state <= S_OUT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SRCH;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_word.prime_value <= new_prime ? PrimeBits'(x) : '0;
            out_word.none_found  <= !new_prime;
            out_word.store_full  <= new_prime && full;
            if (last) seen_count <= '0;
            else if (new_prime && !full) seen_count <= seen_count + CW'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/distinct_prime_filter_top.sv =====
// Top level of the distinct prime filter.
// The time from queue pop to the result word grows with the number of bit-serial trial
// divisions and of recorded entries searched.
// Throughput: one word at a time in the back part; a two-entry queue in front.
// Reset: synchronous; clears the queue, the state machine and the seen count.
module distinct_prime_filter_top import dpf_pkg::*; #(
  parameter int SEEN_DEPTH = SeenDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  logic      in_valid,
  output logic      in_stall,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_stall
);

  logic [ValueBits-1:0] q_value;
  logic                 q_cand;
  logic                 q_last;
  logic                 q_valid;
  logic                 q_pop;

  dpf_front u_front (
    .clk, .rst, .in_word, .in_valid, .in_stall,
    .q_value, .q_cand, .q_last, .q_valid, .q_pop
  );

  dpf_back #(.SEEN_DEPTH(SEEN_DEPTH)) u_back (
    .clk, .rst, .q_value, .q_cand, .q_last, .q_valid, .q_pop,
    .out_word, .out_valid, .out_stall
  );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the distinct prime filter: predicts and checks every result word.
module tb_top;
  import dpf_pkg::*;

  class prime_scoreboard;
    out_word_t pending[$];
    logic [31:0] recorded[$];
    bit failed;

    function bit is_prime(longint unsigned x);
      longint unsigned k;
      if (x < 2) return 0;
      if (x == 2 || x == 3) return 1;
      if (x % 2 == 0 || x % 3 == 0) return 0;
      for (k = 5; k <= x / k; k += 6) begin
        if (x % k == 0 || x % (k + 2) == 0) return 0;
      end
      return 1;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      bit known;
      known = 0;
      foreach (recorded[i]) if (recorded[i] == w.value) known = 1;
      if (!w.value[31] && is_prime(64'(w.value)) && !known) begin
        r.prime_value = w.value[30:0];
        r.none_found = 0;
        r.store_full = (recorded.size() >= SeenDepthDefault);
        if (!r.store_full) recorded.push_back(w.value);
        pending.push_back(r);
      end else if (w.last_item && recorded.size() == 0) begin
        r = '0;
        r.none_found = 1;
        pending.push_back(r);
      end
      if (w.last_item) recorded.delete();
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        failed = 1;
        return;
      end
      want = pending.pop_front();
      if (got.prime_value !== want.prime_value) begin
        $display("%0t: prime_value expected %0d actual %0d", $time,
                 want.prime_value, got.prime_value);
        failed = 1;
      end
      if (got.none_found !== want.none_found) begin
        $display("%0t: none_found expected %b actual %b", $time,
                 want.none_found, got.none_found);
        failed = 1;
      end
      if (got.store_full !== want.store_full) begin
        $display("%0t: store_full expected %b actual %b", $time,
                 want.store_full, got.store_full);
        failed = 1;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  in_word_t in_word;
  logic in_valid;
  logic in_stall;
  out_word_t out_word;
  logic out_valid;
  logic out_stall;
  bit long_hold;
  int idle_cycles;
  prime_scoreboard sb;

  distinct_prime_filter_top u_top (
    .clk(clk), .rst(rst), .in_word(in_word), .in_valid(in_valid),
    .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
    .out_stall(out_stall)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic send_word(logic [31:0] value, logic last);
    int gap;
    in_word_t w;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    w.value = value;
    w.last_item = last;
    in_word <= w;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic send_random_list();
    int len;
    logic [31:0] v;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1: v = $urandom | 32'h8000_0000;
        2: v = $urandom & 32'h7fff_fffe;
        default: v = 32'($urandom_range(0, 3000));
      endcase
      send_word(v, i == len - 1);
    end
  endtask

  task automatic send_full_store_list();
    logic [31:0] primes[$];
    for (int x = 2; primes.size() < 66; x++) if (sb.is_prime(x)) primes.push_back(32'(x));
    primes.shuffle();
    long_hold = 1;
    foreach (primes[i]) send_word(primes[i], 1'b0);
    send_word(primes[65], 1'b0);
    send_word(primes[0], 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_word);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= 3_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int gap;
    out_stall = 0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 7);
      if (long_hold) begin
        long_hold = 0;
        gap = 3000;
      end
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int waited;
    sb = new();
    rst = 1;
    in_valid = 0;
    in_word = '0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(32'd0, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b0);
    send_word(32'd3, 1'b0);
    send_word(32'd3, 1'b0);
    send_word(32'd4, 1'b0);
    send_word(32'd25, 1'b0);
    send_word(32'd121, 1'b0);
    send_word(32'hffff_fff9, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_fffe, 1'b0);
    send_word(32'd7, 1'b1);
    send_word(32'd4, 1'b0);
    send_word(32'd169, 1'b1);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'd11, 1'b0);
    send_word(32'd11, 1'b1);
    send_word(32'd65521, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);

    for (int i = 0; i < 2; i++) send_random_list();
    send_full_store_list();
    for (int i = 0; i < 2; i++) send_random_list();
    in_valid <= 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 3_000_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/dpf_pkg.sv
design/dpf_front.sv
design/dpf_back.sv
design/distinct_prime_filter_top.sv
dv/tb_top.sv
